// ===== rtl/core/pts_pkg.sv =====
// Shared types and constants of the periodic task scheduler table.
package pts_pkg;

  localparam int PTS_NUM_SLOTS = 16;

  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_ADD      = 2'd1;
  localparam logic [1:0] CMD_DELETE   = 2'd2;
  localparam logic [1:0] CMD_DISPATCH = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [7:0] PEND_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  task_code;
    logic [31:0] first_delay;
    logic [31:0] repeat_period;
    logic [3:0]  slot_select;
  } pts_in_t;

  typedef struct packed {
    logic       run_now;
    logic [1:0] status;
    logic [4:0] slot_index;
    logic [7:0] code_out;
    logic       last;
  } pts_out_t;

  typedef struct packed {
    logic [7:0]  code;
    logic [31:0] delay;
    logic [31:0] period;
    logic [7:0]  pending;
  } pts_entry_t;

  typedef struct packed {
    logic        we;
    logic [31:0] delay;
    logic [7:0]  pending;
    logic        run;
    logic        drop;
  } pts_upd_t;

endpackage

// ===== rtl/core/pts_slot_mem.sv =====
// Slot storage: one write port and one registered read port.
module pts_slot_mem #(
  parameter int NUM_SLOTS = pts_pkg::PTS_NUM_SLOTS,
  parameter int IW        = 4
) (
  input  logic               clk,
  input  logic               we,
  input  logic [IW-1:0]      waddr,
  input  pts_pkg::pts_entry_t wdata,
  input  logic [IW-1:0]      raddr,
  output pts_pkg::pts_entry_t rdata
);
  import pts_pkg::*;

  pts_entry_t mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pts_slot_alu.sv =====
// Shared slot update unit: delay countdown, run counting and run removal.
module pts_slot_alu (
  input  logic [1:0]          op,
  input  logic                vld,
  input  pts_pkg::pts_entry_t ent,
  output pts_pkg::pts_upd_t   upd
);
  import pts_pkg::*;

  logic [7:0] pend;

  always_comb begin
    pend = vld ? ent.pending : 8'd0;
    upd  = '0;
    upd.delay   = ent.delay;
    upd.pending = ent.pending;
    case (op)
      CMD_TICK: begin
        upd.we = vld;
        if (ent.delay != 32'd0) begin
          upd.delay = ent.delay - 32'd1;
        end else begin
          upd.delay   = ent.period;
          upd.pending = (ent.pending == PEND_MAX) ? PEND_MAX : ent.pending + 8'd1;
        end
      end
      CMD_DISPATCH: begin
        upd.run     = (pend != 8'd0);
        upd.we      = upd.run;
        upd.pending = pend - 8'd1;
        upd.drop    = upd.run && (ent.period == 32'd0);
      end
      default: begin
        upd.we = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/periodic_task_scheduler_table_core.sv =====
// Top level: command sequencer that walks the slot table one slot per cycle.
// Tick and dispatch walk every slot; a dispatch strobes a run result, in slot order, for each slot with a pending run.
// Add: walks to the first free slot and stops there; a full table is walked to its end.
// Delete: finishes in the accept cycle; its result strobes the next cycle, busy stays low.
// The final result of a walk strobes in the cycle busy drops; the slot walk sets the rate.
// Synchronous reset empties the table at once; results cannot be stalled by the receiver.
module periodic_task_scheduler_table_core #(
  parameter int NUM_SLOTS = pts_pkg::PTS_NUM_SLOTS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pts_pkg::pts_in_t item,
  output logic             strobe,
  output pts_pkg::pts_out_t result
);
  import pts_pkg::*;

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  typedef enum logic {IDLE, WALK} state_t;

  state_t          state;
  pts_in_t         req;
  logic [CW-1:0]   idx;
  logic [IW-1:0]   raddr;
  logic [IW-1:0]   rd_idx;
  logic            rd_vld;
  logic            v_q;
  logic            issue;
  logic [NUM_SLOTS-1:0] slot_valid;
  pts_entry_t      rd_ent;
  pts_entry_t      wdata;
  pts_upd_t        upd;
  logic            mem_we;
  logic            add_hit;
  logic            sel_ok;
  logic [IW-1:0]   sel;

  assign busy   = (state != IDLE);
  assign issue  = (idx < CW'(NUM_SLOTS));
  assign raddr  = idx[IW-1:0];
  assign sel    = IW'(item.slot_select);
  assign sel_ok = (32'(item.slot_select) < 32'(NUM_SLOTS));
  assign add_hit = (state == WALK) && rd_vld && (req.cmd == CMD_ADD) && !v_q;

  pts_slot_alu u_alu (
    .op  (req.cmd),
    .vld (v_q),
    .ent (rd_ent),
    .upd (upd)
  );

  always_comb begin
    mem_we = add_hit || ((state == WALK) && rd_vld && upd.we);
    if (req.cmd == CMD_ADD) begin
      wdata.code    = req.task_code;
      wdata.delay   = req.first_delay;
      wdata.period  = req.repeat_period;
      wdata.pending = 8'd0;
    end else begin
      wdata.code    = rd_ent.code;
      wdata.delay   = upd.delay;
      wdata.period  = rd_ent.period;
      wdata.pending = upd.pending;
    end
  end

  pts_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .IW        (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (rd_idx),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_ent)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      strobe     <= 1'b0;
      rd_vld     <= 1'b0;
      idx        <= '0;
      slot_valid <= '0;
    end else begin
      strobe <= 1'b0;
      case (state)
        IDLE: begin
          rd_vld <= 1'b0;
          if (start) begin
            req <= item;
            idx <= '0;
            if (item.cmd == CMD_DELETE) begin
              strobe            <= 1'b1;
              result            <= '0;
              result.last       <= 1'b1;
              result.slot_index <= 5'(item.slot_select);
              if (sel_ok && slot_valid[sel]) begin
                slot_valid[sel] <= 1'b0;
                result.status   <= ST_OK;
              end else begin
                result.status   <= ST_EMPTY;
              end
            end else begin
              state <= WALK;
            end
          end
        end
        WALK: begin
          rd_vld <= issue;
          rd_idx <= raddr;
          v_q    <= slot_valid[raddr];
          if (issue) begin
            idx <= idx + CW'(1);
          end
          if (add_hit) begin
            slot_valid[rd_idx] <= 1'b1;
            strobe             <= 1'b1;
            result             <= '0;
            result.last        <= 1'b1;
            result.slot_index  <= 5'(rd_idx);
            rd_vld             <= 1'b0;
            state              <= IDLE;
          end else if (rd_vld && (req.cmd == CMD_DISPATCH) && upd.run) begin
            strobe            <= 1'b1;
            result            <= '0;
            result.run_now    <= 1'b1;
            result.slot_index <= 5'(rd_idx);
            result.code_out   <= rd_ent.code;
            if (upd.drop) begin
              slot_valid[rd_idx] <= 1'b0;
            end
          end
          if (!issue && !rd_vld) begin
            strobe      <= 1'b1;
            result      <= '0;
            result.last <= 1'b1;
            if (req.cmd == CMD_ADD) begin
              result.status     <= ST_FULL;
              result.slot_index <= 5'(NUM_SLOTS);
            end
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_run_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && result.run_now |-> !result.last)
    else $error("run result marked last");

  a_nonlast_is_run: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> result.run_now)
    else $error("non-final result without run");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("walk began without a transfer");

  a_read_in_walk: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> state == WALK)
    else $error("slot read pending outside walk");

endmodule

// ===== tb/pts_schedule_checker.sv =====
// Checker for the task scheduler table: predicts every transfer and compares results.
`timescale 1ns / 1ps
module pts_schedule_checker #(
  parameter int NUM_SLOTS = pts_pkg::PTS_NUM_SLOTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  pts_pkg::pts_in_t  item,
  input  logic              strobe,
  input  pts_pkg::pts_out_t result,
  output int                mismatches,
  output int                outstanding
);
  import pts_pkg::*;

  logic        occupied [NUM_SLOTS];
  logic [7:0]  task_id  [NUM_SLOTS];
  logic [31:0] countdown[NUM_SLOTS];
  logic [31:0] reload   [NUM_SLOTS];
  logic [7:0]  backlog  [NUM_SLOTS];

  pts_out_t due_results[$];

  task automatic clear_slot(input int s);
    occupied[s]  = 1'b0;
    task_id[s]   = '0;
    countdown[s] = '0;
    reload[s]    = '0;
    backlog[s]   = '0;
  endtask

  task automatic apply_command(input pts_in_t it);
    pts_out_t r;
    int s;
    r = '0;
    r.last = 1'b1;
    case (it.cmd)
      CMD_TICK: begin
        for (s = 0; s < NUM_SLOTS; s++) begin
          if (occupied[s]) begin
            if (countdown[s] != 0) begin
              countdown[s] = countdown[s] - 32'd1;
            end else begin
              if (backlog[s] != PEND_MAX) backlog[s] = backlog[s] + 8'd1;
              countdown[s] = reload[s];
            end
          end
        end
      end
      CMD_ADD: begin
        s = 0;
        while (s < NUM_SLOTS && occupied[s]) s++;
        if (s == NUM_SLOTS) begin
          r.status     = ST_FULL;
          r.slot_index = 5'(NUM_SLOTS);
        end else begin
          occupied[s]  = 1'b1;
          task_id[s]   = it.task_code;
          countdown[s] = it.first_delay;
          reload[s]    = it.repeat_period;
          backlog[s]   = '0;
          r.slot_index = 5'(s);
        end
      end
      CMD_DELETE: begin
        r.slot_index = 5'(it.slot_select);
        if (int'(it.slot_select) >= NUM_SLOTS || !occupied[it.slot_select]) begin
          r.status = ST_EMPTY;
        end else begin
          clear_slot(int'(it.slot_select));
        end
      end
      default: begin
        for (s = 0; s < NUM_SLOTS; s++) begin
          if (backlog[s] != 0) begin
            pts_out_t run;
            run            = '0;
            run.run_now    = 1'b1;
            run.status     = ST_OK;
            run.slot_index = 5'(s);
            run.code_out   = task_id[s];
            due_results.push_back(run);
            backlog[s] = backlog[s] - 8'd1;
            if (reload[s] == 0) clear_slot(s);
          end
        end
      end
    endcase
    due_results.push_back(r);
  endtask

  task automatic report(input string field, input int want, input int got);
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    mismatches++;
  endtask

  task automatic check_result(input pts_out_t got);
    pts_out_t want;
    if (due_results.size() == 0) begin
      $display("%0t: result with none expected, actual %h", $time, got);
      mismatches++;
      return;
    end
    want = due_results.pop_front();
    if (got.run_now !== want.run_now)
      report("run_now", int'(want.run_now), int'(got.run_now));
    if (got.status !== want.status)
      report("status", int'(want.status), int'(got.status));
    if (got.slot_index !== want.slot_index)
      report("slot_index", int'(want.slot_index), int'(got.slot_index));
    if (got.code_out !== want.code_out)
      report("code_out", int'(want.code_out), int'(got.code_out));
    if (got.last !== want.last)
      report("last", int'(want.last), int'(got.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SLOTS; s++) clear_slot(s);
      due_results.delete();
    end else begin
      if (strobe) check_result(result);
      if (start && !busy) apply_command(item);
    end
    outstanding <= due_results.size();
  end

endmodule

// ===== tb/tb_periodic_task_scheduler_table_core.sv =====
// Testbench top for the task scheduler table: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module tb_periodic_task_scheduler_table_core;
  import pts_pkg::*;

  localparam int NUM_SLOTS   = PTS_NUM_SLOTS;
  localparam int CYCLE_LIMIT = 200000;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  pts_in_t  item;
  logic     strobe;
  pts_out_t result;
  int       mismatches;
  int       outstanding;
  int       cycles;

  periodic_task_scheduler_table_core #(.NUM_SLOTS(NUM_SLOTS)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  pts_schedule_checker #(.NUM_SLOTS(NUM_SLOTS)) u_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .strobe      (strobe),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic pts_in_t noise_item(input logic [1:0] cmd);
    pts_in_t it;
    it.cmd           = cmd;
    it.task_code     = 8'($urandom_range(0, 255));
    it.first_delay   = $urandom;
    it.repeat_period = $urandom;
    it.slot_select   = 4'($urandom_range(0, 15));
    return it;
  endfunction

  function automatic pts_in_t add_item(input logic [7:0] code, input logic [31:0] delay,
                                       input logic [31:0] period);
    pts_in_t it;
    it               = noise_item(CMD_ADD);
    it.task_code     = code;
    it.first_delay   = delay;
    it.repeat_period = period;
    return it;
  endfunction

  function automatic pts_in_t delete_item(input logic [3:0] sel);
    pts_in_t it;
    it             = noise_item(CMD_DELETE);
    it.slot_select = sel;
    return it;
  endfunction

  task automatic send(input pts_in_t it, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic int draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 12);
  endfunction

  initial begin
    pts_in_t it;
    bit      burst;
    int      pick;
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(noise_item(CMD_TICK), draw_gap(1'b0));
    send(noise_item(CMD_DISPATCH), draw_gap(1'b0));
    send(delete_item(4'd15), draw_gap(1'b0));
    send(add_item(8'hFF, 32'd0, 32'd0), draw_gap(1'b0));
    send(add_item(8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF), draw_gap(1'b0));
    send(add_item(8'h3C, 32'd1, 32'd1), draw_gap(1'b0));
    for (int s = 3; s < NUM_SLOTS; s++)
      send(add_item(8'($urandom_range(0, 255)), $urandom_range(0, 3), $urandom_range(0, 2)),
           draw_gap(s % 3 == 0));
    send(add_item(8'h81, 32'd0, 32'd0), draw_gap(1'b0));
    repeat (3) send(noise_item(CMD_TICK), draw_gap(1'b0));
    send(noise_item(CMD_DISPATCH), draw_gap(1'b0));
    send(delete_item(4'd2), draw_gap(1'b1));
    send(delete_item(4'd2), draw_gap(1'b1));
    drain_results();

    for (int n = 0; n < 110; n++) begin
      if (n % 20 == 0) burst = ($urandom_range(0, 2) == 0);
      if (n == 55) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        it = noise_item(CMD_TICK);
      end else if (pick < 65) begin
        it = noise_item(CMD_ADD);
        if ($urandom_range(0, 9) != 0) it.first_delay = $urandom_range(0, 4);
        if ($urandom_range(0, 9) != 0) it.repeat_period = $urandom_range(0, 3);
      end else if (pick < 80) begin
        it = noise_item(CMD_DELETE);
      end else begin
        it = noise_item(CMD_DISPATCH);
      end
      send(it, draw_gap(burst));
    end

    for (int s = 0; s < NUM_SLOTS; s++) send(delete_item(4'(s)), draw_gap(1'b1));
    send(add_item(8'hA5, 32'd0, 32'd0), draw_gap(1'b0));
    send(add_item(8'h5A, 32'd0, 32'd0), draw_gap(1'b0));
    send(add_item(8'hC3, 32'd0, 32'd1), draw_gap(1'b0));
    repeat (10) send(noise_item(CMD_TICK), draw_gap(1'b1));
    send(noise_item(CMD_DISPATCH), draw_gap(1'b0));
    send(noise_item(CMD_DISPATCH), draw_gap(1'b0));

    drain_results();
    repeat (NUM_SLOTS + 4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
